FILE: hdl/htsc_pkg.sv
`timescale 1ns / 1ps

package htsc_pkg;

  localparam int unsigned SlotsDef   = 1024;
  localparam int unsigned BucketsDef = 256;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SWEEP  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_LK_HEAD,
    ST_LK_FIRST,
    ST_LK_CHK,
    ST_IN_START,
    ST_IN_POP,
    ST_IN_WALK,
    ST_SW_BKT,
    ST_SW_HEAD,
    ST_SW_NODE,
    ST_SW_FREE,
    ST_CLR,
    ST_RESP
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_INIT,
    CMD_HASH,
    CMD_LK_HEAD,
    CMD_LK_FIRST,
    CMD_LK_CHK,
    CMD_IN_START,
    CMD_IN_POP,
    CMD_IN_WALK,
    CMD_SW_BKT,
    CMD_SW_HEAD,
    CMD_SW_NODE,
    CMD_SW_FREE,
    CMD_RESP
  } cmd_e;

  typedef struct packed {
    logic [1:0] op;
    logic       hash_done;
    logic       head_nil;
    logic       nxt_nil;
    logic       key_match;
    logic       stale;
    logic       free_empty;
    logic       last_bkt;
    logic       init_last;
    logic       out_busy;
  } dp_status_t;

endpackage

FILE: hdl/htsc_if.sv
`timescale 1ns / 1ps

interface htsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] tile_key;
  logic [31:0] current_frame;

  modport source (output valid, output opcode, output tile_key, output current_frame,
                  input ready);
  modport sink (input valid, input opcode, input tile_key, input current_frame,
                output ready);
endinterface

interface htsc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  slot;
  logic [10:0] entries_in_use;

  modport source (output valid, output status, output slot, output entries_in_use,
                  input ready);
  modport sink (input valid, input status, input slot, input entries_in_use,
                output ready);
endinterface

FILE: hdl/htsc_ctrl.sv
`timescale 1ns / 1ps

module htsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  htsc_pkg::dp_status_t status_i,
  output htsc_pkg::cmd_e      cmd_o
);
  import htsc_pkg::*;

  state_e state_q, state_d;
  state_e adv_state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    if (status_i.nxt_nil) begin
      adv_state = status_i.last_bkt ? ST_RESP : ST_SW_BKT;
    end else begin
      adv_state = ST_SW_NODE;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: if (status_i.init_last) state_d = ST_IDLE;
      ST_CLR: if (status_i.init_last) state_d = ST_RESP;
      ST_IDLE: if (in_valid_i) state_d = ST_HASH;
      ST_HASH: begin
        if (status_i.hash_done) begin
          unique case (status_i.op)
            OP_LOOKUP: state_d = ST_LK_HEAD;
            OP_INSERT: state_d = ST_IN_START;
            OP_SWEEP:  state_d = ST_SW_BKT;
            default:   state_d = ST_CLR;
          endcase
        end
      end
      ST_LK_HEAD: state_d = ST_LK_FIRST;
      ST_LK_FIRST: state_d = status_i.head_nil ? ST_RESP : ST_LK_CHK;
      ST_LK_CHK: if (status_i.key_match || status_i.nxt_nil) state_d = ST_RESP;
      ST_IN_START: state_d = status_i.free_empty ? ST_RESP : ST_IN_POP;
      ST_IN_POP: state_d = status_i.head_nil ? ST_RESP : ST_IN_WALK;
      ST_IN_WALK: if (status_i.nxt_nil) state_d = ST_RESP;
      ST_SW_BKT: state_d = ST_SW_HEAD;
      ST_SW_HEAD: begin
        if (status_i.head_nil) begin
          state_d = status_i.last_bkt ? ST_RESP : ST_SW_BKT;
        end else begin
          state_d = ST_SW_NODE;
        end
      end
      ST_SW_NODE: state_d = status_i.stale ? ST_SW_FREE : adv_state;
      ST_SW_FREE: state_d = adv_state;
      ST_RESP: if (!status_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = CMD_NONE;
    unique case (state_q)
      ST_INIT, ST_CLR: cmd_o = CMD_INIT;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o      = in_valid_i ? CMD_ACCEPT : CMD_NONE;
      end
      ST_HASH:     cmd_o = CMD_HASH;
      ST_LK_HEAD:  cmd_o = CMD_LK_HEAD;
      ST_LK_FIRST: cmd_o = CMD_LK_FIRST;
      ST_LK_CHK:   cmd_o = CMD_LK_CHK;
      ST_IN_START: cmd_o = CMD_IN_START;
      ST_IN_POP:   cmd_o = CMD_IN_POP;
      ST_IN_WALK:  cmd_o = CMD_IN_WALK;
      ST_SW_BKT:   cmd_o = CMD_SW_BKT;
      ST_SW_HEAD:  cmd_o = CMD_SW_HEAD;
      ST_SW_NODE:  cmd_o = CMD_SW_NODE;
      ST_SW_FREE:  cmd_o = CMD_SW_FREE;
      ST_RESP:     cmd_o = CMD_RESP;
      default:     cmd_o = CMD_NONE;
    endcase
  end

endmodule

FILE: hdl/htsc_datapath.sv
`timescale 1ns / 1ps

module htsc_datapath #(
  parameter int unsigned SLOTS   = htsc_pkg::SlotsDef,
  parameter int unsigned BUCKETS = htsc_pkg::BucketsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  htsc_pkg::cmd_e       cmd_i,
  output htsc_pkg::dp_status_t status_o,
  input  logic [1:0]           opcode_i,
  input  logic [31:0]          tile_key_i,
  input  logic [31:0]          current_frame_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o_field,
  output logic [9:0]           slot_o,
  output logic [10:0]          entries_in_use_o
);
  import htsc_pkg::*;

  localparam int unsigned LW   = $clog2(SLOTS + 1);
  localparam int unsigned SW   = $clog2(SLOTS);
  localparam int unsigned BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned MAXN = (SLOTS > BUCKETS) ? SLOTS : BUCKETS;
  localparam int unsigned IW   = $clog2(MAXN);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);
  localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  logic [LW-1:0] next_mem [SLOTS];
  logic [LW-1:0] head_mem [BUCKETS];
  logic [31:0]   key_mem [SLOTS];
  logic [31:0]   stamp_mem [SLOTS];

  logic [LW-1:0] next_rd, head_rd;
  logic [31:0]   key_rd, stamp_rd;

  logic [1:0]    op_q;
  logic [31:0]   key_q, frame_q;
  logic [BW-1:0] bkt_q;
  logic [LW-1:0] free_head_q, p_q, q_q, prev_q, nxt_q, count_q;
  logic [SW-1:0] res_slot_q;
  logic [1:0]    res_stat_q;
  logic [IW-1:0] i_q;
  logic          out_valid_q;
  logic [1:0]    out_stat_q;
  logic [9:0]    out_slot_q;
  logic [10:0]   out_cnt_q;

  logic [LW-1:0] rd_ptr, adv_ptr;
  logic [SW-1:0] rd_addr;
  logic          head_nil, nxt_nil, key_match, stale, last_bkt, init_last;
  logic          hash_done, out_busy;
  logic [BW-1:0] hash_val;

  logic          nw_en, bw_en, kw_en, sw_en;
  logic [SW-1:0] nw_addr, kw_addr, sw_addr;
  logic [LW-1:0] nw_data, bw_data;
  logic [BW-1:0] bw_addr;
  logic [31:0]   sw_data;

  generate
    if (BKT_POW2) begin : g_hash_mask
      if (BUCKETS > 1) begin : g_bits
        assign hash_val = key_q[BW-1:0];
      end else begin : g_one
        assign hash_val = '0;
      end
      assign hash_done = 1'b1;
    end else begin : g_hash_recip
      localparam logic [31:0] Recip = 32'(64'h1_0000_0000 / 64'(BUCKETS));
      logic [47:0] prod_lo, prod_hi, prod_lo_q;
      logic [63:0] prod_q;
      logic [31:0] quot_b, rem_wide;
      logic [BW:0] rem0_q, rem_q;
      logic [2:0]  hcnt_q;
      assign prod_lo   = 48'(key_q[15:0]) * 48'(Recip);
      assign prod_hi   = 48'(key_q[31:16]) * 48'(Recip);
      assign quot_b    = prod_q[63:32] * 32'(BUCKETS);
      assign rem_wide  = key_q - quot_b;
      assign hash_done = (hcnt_q == 3'd4);
      assign hash_val  = rem_q[BW-1:0];
      always_ff @(posedge clk_i) begin
        if (cmd_i == CMD_ACCEPT) begin
          hcnt_q <= '0;
        end else if (cmd_i == CMD_HASH && !hash_done) begin
          case (hcnt_q)
            3'd0: prod_lo_q <= prod_lo;
            3'd1: prod_q <= 64'(prod_lo_q) + {prod_hi, 16'b0};
            3'd2: rem0_q <= rem_wide[BW:0];
            default: begin
              rem_q <= (rem0_q >= (BW + 1)'(BUCKETS)) ? rem0_q - (BW + 1)'(BUCKETS) : rem0_q;
            end
          endcase
          hcnt_q <= hcnt_q + 3'd1;
        end
      end
    end
  endgenerate

  assign head_nil  = (head_rd == NIL);
  assign adv_ptr   = (cmd_i == CMD_SW_FREE) ? nxt_q : next_rd;
  assign nxt_nil   = (adv_ptr == NIL);
  assign key_match = (key_rd == key_q);
  assign stale     = (stamp_rd != frame_q);
  assign last_bkt  = (bkt_q == BW'(BUCKETS - 1));
  assign init_last = (32'(i_q) == MAXN - 1);
  assign out_busy  = out_valid_q && !out_ready_i;

  always_comb begin
    status_o            = '0;
    status_o.op         = op_q;
    status_o.hash_done  = hash_done;
    status_o.head_nil   = head_nil;
    status_o.nxt_nil    = nxt_nil;
    status_o.key_match  = key_match;
    status_o.stale      = stale;
    status_o.free_empty = (free_head_q == NIL);
    status_o.last_bkt   = last_bkt;
    status_o.init_last  = init_last;
    status_o.out_busy   = out_busy;
  end

  always_comb begin
    case (cmd_i)
      CMD_IN_START:                          rd_ptr = free_head_q;
      CMD_LK_FIRST, CMD_IN_POP, CMD_SW_HEAD: rd_ptr = head_rd;
      default:                               rd_ptr = adv_ptr;
    endcase
    rd_addr = rd_ptr[SW-1:0];
  end

  always_comb begin
    nw_en   = 1'b0;
    nw_addr = p_q[SW-1:0];
    nw_data = NIL;
    bw_en   = 1'b0;
    bw_addr = bkt_q;
    bw_data = NIL;
    kw_en   = 1'b0;
    kw_addr = q_q[SW-1:0];
    sw_en   = 1'b0;
    sw_addr = q_q[SW-1:0];
    sw_data = frame_q;
    case (cmd_i)
      CMD_INIT: begin
        nw_en   = (32'(i_q) < SLOTS);
        nw_addr = SW'(i_q);
        nw_data = LW'(32'(i_q) + 32'd1);
        bw_en   = (32'(i_q) < BUCKETS);
        bw_addr = BW'(i_q);
      end
      CMD_IN_POP: begin
        nw_en   = 1'b1;
        nw_addr = q_q[SW-1:0];
        bw_en   = head_nil;
        bw_data = q_q;
        kw_en   = 1'b1;
        sw_en   = 1'b1;
      end
      CMD_IN_WALK: begin
        nw_en   = nxt_nil;
        nw_data = q_q;
      end
      CMD_LK_CHK: begin
        sw_en   = key_match;
        sw_addr = p_q[SW-1:0];
      end
      CMD_SW_NODE: begin
        nw_en   = stale && (prev_q != NIL);
        nw_addr = prev_q[SW-1:0];
        nw_data = next_rd;
        bw_en   = stale && (prev_q == NIL);
        bw_data = next_rd;
      end
      CMD_SW_FREE: begin
        nw_en   = 1'b1;
        nw_data = free_head_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nw_en) next_mem[nw_addr] <= nw_data;
    if (bw_en) head_mem[bw_addr] <= bw_data;
    if (kw_en) key_mem[kw_addr] <= key_q;
    if (sw_en) stamp_mem[sw_addr] <= sw_data;
    next_rd  <= next_mem[rd_addr];
    key_rd   <= key_mem[rd_addr];
    stamp_rd <= stamp_mem[rd_addr];
    head_rd  <= head_mem[bkt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      free_head_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_INIT: begin
          i_q         <= init_last ? '0 : i_q + IW'(1);
          free_head_q <= '0;
          count_q     <= '0;
        end
        CMD_IN_POP: begin
          free_head_q <= next_rd;
          if (head_nil) count_q <= count_q + LW'(1);
        end
        CMD_IN_WALK: if (nxt_nil) count_q <= count_q + LW'(1);
        CMD_SW_NODE: if (stale && count_q != '0) count_q <= count_q - LW'(1);
        CMD_SW_FREE: free_head_q <= p_q;
        default: ;
      endcase
      if (cmd_i == CMD_RESP && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_ACCEPT: begin
        op_q    <= opcode_i;
        key_q   <= tile_key_i;
        frame_q <= current_frame_i;
      end
      CMD_INIT: begin
        res_stat_q <= STAT_OK;
        res_slot_q <= '0;
      end
      CMD_HASH: bkt_q <= (op_q == OP_SWEEP) ? '0 : hash_val;
      CMD_LK_FIRST: begin
        res_stat_q <= STAT_MISS;
        res_slot_q <= '0;
        p_q        <= head_rd;
      end
      CMD_LK_CHK: begin
        if (key_match) begin
          res_stat_q <= STAT_OK;
          res_slot_q <= p_q[SW-1:0];
        end else begin
          p_q <= next_rd;
        end
      end
      CMD_IN_START: begin
        res_stat_q <= STAT_FULL;
        res_slot_q <= '0;
        q_q        <= free_head_q;
      end
      CMD_IN_POP: begin
        res_stat_q <= STAT_OK;
        res_slot_q <= q_q[SW-1:0];
        p_q        <= head_rd;
      end
      CMD_IN_WALK: p_q <= next_rd;
      CMD_SW_BKT: begin
        prev_q     <= NIL;
        res_stat_q <= STAT_OK;
        res_slot_q <= '0;
      end
      CMD_SW_HEAD: begin
        p_q <= head_rd;
        if (head_nil && !last_bkt) bkt_q <= bkt_q + BW'(1);
      end
      CMD_SW_NODE, CMD_SW_FREE: begin
        if (cmd_i == CMD_SW_NODE) begin
          nxt_q <= next_rd;
          if (!stale) prev_q <= p_q;
        end
        if (cmd_i == CMD_SW_FREE || !stale) begin
          p_q <= adv_ptr;
          if (nxt_nil && !last_bkt) bkt_q <= bkt_q + BW'(1);
        end
      end
      CMD_RESP: begin
        if (!out_busy) begin
          out_stat_q <= res_stat_q;
          out_slot_q <= 10'(res_slot_q);
          out_cnt_q  <= 11'(count_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign status_o_field   = out_stat_q;
  assign slot_o           = out_slot_q;
  assign entries_in_use_o = out_cnt_q;

endmodule

FILE: hdl/hashed_tile_slot_cache.sv
`timescale 1ns / 1ps

// Channel  Role    Payload
// in_i     sink    opcode, tile_key, current_frame
// out_o    source  status, slot, entries_in_use
//
// One transaction is handled at a time; each input transaction yields one result.
// Lookup walks the bucket chain node by node, insert walks it to the tail, and sweep
// visits every bucket and each chained slot; all of them add steps of bucket hashing
// when BUCKETS is not a power of two. Reset and clear run an initialising pass over
// the link and bucket memories; no input is taken during it.
// The result waits in an output register while out_o is stalled.

module hashed_tile_slot_cache #(
  parameter int unsigned SLOTS   = htsc_pkg::SlotsDef,
  parameter int unsigned BUCKETS = htsc_pkg::BucketsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htsc_in_if.sink    in_i,
  htsc_out_if.source out_o
);
  import htsc_pkg::*;

  cmd_e       cmd;
  dp_status_t dp_status;

  htsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  htsc_datapath #(
    .SLOTS   (SLOTS),
    .BUCKETS (BUCKETS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (dp_status),
    .opcode_i         (in_i.opcode),
    .tile_key_i       (in_i.tile_key),
    .current_frame_i  (in_i.current_frame),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .status_o_field   (out_o.status),
    .slot_o           (out_o.slot),
    .entries_in_use_o (out_o.entries_in_use)
  );

endmodule

FILE: test/htsc_checker.sv
`timescale 1ns / 1ps

module htsc_checker #(
  parameter int unsigned SLOTS   = htsc_pkg::SlotsDef,
  parameter int unsigned BUCKETS = htsc_pkg::BucketsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  htsc_in_if   in_mon,
  htsc_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import htsc_pkg::*;

  localparam int unsigned Nil = SLOTS;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [10:0] entries_in_use;
  } slot_result_t;

  int unsigned  bucket_head [BUCKETS];
  int unsigned  next_link [SLOTS];
  logic [31:0]  slot_key [SLOTS];
  logic [31:0]  slot_stamp [SLOTS];
  int unsigned  free_head;
  int unsigned  used_count;
  slot_result_t expected_results [$];
  int           fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_results.size();

  function automatic void rebuild_pool();
    for (int i = 0; i < SLOTS; i++) next_link[i] = i + 1;
    next_link[SLOTS-1] = Nil;
    for (int i = 0; i < BUCKETS; i++) bucket_head[i] = Nil;
    free_head  = 0;
    used_count = 0;
  endfunction

  function automatic slot_result_t cache_step(logic [1:0] op, logic [31:0] key,
                                              logic [31:0] frame);
    slot_result_t r;
    int unsigned  b, p, q, prev, nxt;
    b = key % BUCKETS;
    r.status = STAT_OK;
    r.slot   = '0;
    case (op)
      OP_LOOKUP: begin
        r.status = STAT_MISS;
        p = bucket_head[b];
        while (p < Nil) begin
          if (slot_key[p] == key) begin
            slot_stamp[p] = frame;
            r.status = STAT_OK;
            r.slot   = p[9:0];
            break;
          end
          p = next_link[p];
        end
      end
      OP_INSERT: begin
        q = free_head;
        if (q >= Nil) begin
          r.status = STAT_FULL;
        end else begin
          free_head     = next_link[q];
          next_link[q]  = Nil;
          slot_key[q]   = key;
          slot_stamp[q] = frame;
          p = bucket_head[b];
          if (p >= Nil) begin
            bucket_head[b] = q;
          end else begin
            while (next_link[p] < Nil) p = next_link[p];
            next_link[p] = q;
          end
          used_count++;
          r.slot = q[9:0];
        end
      end
      OP_SWEEP: begin
        for (int unsigned bk = 0; bk < BUCKETS; bk++) begin
          prev = Nil;
          p = bucket_head[bk];
          while (p < Nil) begin
            nxt = next_link[p];
            if (slot_stamp[p] != frame) begin
              if (used_count > 0) used_count--;
              if (prev >= Nil) bucket_head[bk] = nxt;
              else next_link[prev] = nxt;
              next_link[p] = free_head;
              free_head = p;
            end else begin
              prev = p;
            end
            p = nxt;
          end
        end
      end
      default: rebuild_pool();
    endcase
    r.entries_in_use = used_count[10:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t got, want;
    if (!rst_ni) begin
      rebuild_pool();
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(cache_step(in_mon.opcode, in_mon.tile_key,
                                              in_mon.current_frame));
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.status, out_mon.slot, out_mon.entries_in_use};
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected result transaction: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("Mismatch: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                       want.status, want.slot, want.entries_in_use,
                       got.status, got.slot, got.entries_in_use);
          end
        end
      end
    end
  end
endmodule

FILE: test/hashed_tile_slot_cache_tb.sv
`timescale 1ns / 1ps

module hashed_tile_slot_cache_tb;
  import htsc_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   stim_done;
  logic [31:0] frame;
  logic [31:0] keys [$];

  htsc_in_if  in_ch ();
  htsc_out_if out_ch ();

  hashed_tile_slot_cache dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  htsc_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send(logic [1:0] op, logic [31:0] key, logic [31:0] frm);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.tile_key      <= key;
    in_ch.current_frame <= frm;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic logic [31:0] pick_key();
    if (keys.size() > 0 && $urandom_range(0, 2) != 0)
      return keys[$urandom_range(0, keys.size() - 1)];
    return $urandom_range(0, 3) == 0 ? {24'($urandom_range(0, 15)), 8'h05} : $urandom;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOOKUP;
    in_ch.tile_key = '0;
    in_ch.current_frame = '0;
    out_ch.ready = 1'b0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(OP_LOOKUP, 32'h0, 32'h0);
    send(OP_INSERT, 32'h0, 32'h0);
    send(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_INSERT, 32'h0000_0100, 32'h1);
    send(OP_INSERT, 32'h0, 32'h2);
    send(OP_LOOKUP, 32'h0000_0100, 32'h0);
    send(OP_LOOKUP, 32'h0, 32'h0);
    send(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send(OP_LOOKUP, 32'h0000_0200, 32'h0);
    send(OP_SWEEP, 32'hFFFF_FFFF, 32'h0);
    send(OP_LOOKUP, 32'h0, 32'h0);
    send(OP_INSERT, 32'hA5A5_5A5A, 32'h7);
    send(OP_CLEAR, 32'h1234_5678, 32'h0);
    send(OP_LOOKUP, 32'h0, 32'h0);
    for (int i = 0; i < 1025; i++)
      send(OP_INSERT, i[1:0] == 0 ? ~i : i, 32'h55);
    send(OP_SWEEP, 32'h0, 32'h55);
    send(OP_SWEEP, 32'h0, 32'hAAAA_AAAA);
    send(OP_LOOKUP, 32'h1, 32'h0);

    frame = 32'h10;
    for (int i = 0; i < 260; i++) begin
      int r;
      logic [31:0] k;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send(OP_LOOKUP, pick_key(), frame);
      end else if (r < 88) begin
        k = pick_key();
        keys.push_back(k);
        if (keys.size() > 64) void'(keys.pop_front());
        send(OP_INSERT, k, frame);
      end else if (r < 98) begin
        send(OP_SWEEP, $urandom, $urandom_range(0, 4) == 0 ? $urandom : frame);
        frame = frame + 1;
      end else begin
        send(OP_CLEAR, $urandom, $urandom);
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int gap;
    forever begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("hashed_tile_slot_cache test failed");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("hashed_tile_slot_cache test passed");
    end else begin
      $display("hashed_tile_slot_cache test failed");
    end
    $finish;
  end
endmodule
